/* sv/assert_macros.svh */
// Assertion macros included by the collision block.
// No dependencies; clock clk_i and reset rst_ni are taken from the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* sv/sws_pkg.sv */
// Types, constants and saturation helpers for the sphere/wall-span collision block.
// No dependencies.
`timescale 1ns / 1ps

package sws_pkg;

  localparam int WORD_W      = 32;   // width of the stored centre and velocity words
  localparam int FLD_W       = 32;
  localparam int RAD_W       = 31;
  localparam int STEP_W      = 31;
  localparam int EPS_W       = 17;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MUL_A_W     = 34;
  localparam int MUL_B_W     = 32;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam int DIV_CNT_W   = 6;
  localparam int DIV_FRAC_STEPS = 16;
  localparam int DIV_INT_STEPS  = 34;

  localparam int PEN_SLOP    = 66;     // 0.001 in Q16.16
  localparam int GROUND_SLOP = 1638;   // 0.025 in Q16.16
  localparam int ONE_Q16     = 65536;

  localparam logic [RAD_W-1:0]  RAD_RESET  = RAD_W'(32768);
  localparam logic [STEP_W-1:0] STEP_RESET = '0;
  localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(7);

  localparam logic signed [63:0] W_MAX = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
  localparam logic signed [63:0] W_MIN = -W_MAX - 64'sd1;
  localparam logic signed [63:0] S31_MAX = 64'sd2147483647;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_STEP   = 2'd1,
    CFG_EPS    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TEST = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    AX_CX = 3'd0,
    AX_CY = 3'd1,
    AX_CZ = 3'd2,
    AX_VX = 3'd3,
    AX_VY = 3'd4,
    AX_VZ = 3'd5
  } axis_e;

  typedef enum logic [5:0] {
    S_IDLE, S_BOX,
    S_L1, S_L2, S_L3, S_L4, S_L5, S_TDIV,
    S_I1, S_I2, S_I3, S_I4, S_I5,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_D5,
    S_DSQ, S_ESQ, S_EDIV, S_PEN, S_HDIV,
    S_F1, S_F2, S_F3,
    S_A1, S_A2, S_A3, S_LSQ, S_UXD, S_UZD,
    S_V1, S_V2, S_V3, S_DEC,
    S_P1, S_P2, S_P3, S_P4, S_P5,
    S_OUT
  } state_e;

  typedef struct packed {
    logic                    action;
    logic [2:0]              body_axis;
    logic signed [FLD_W-1:0] body_value;
    logic signed [FLD_W-1:0] wall_start_x;
    logic signed [FLD_W-1:0] wall_start_z;
    logic signed [FLD_W-1:0] wall_end_x;
    logic signed [FLD_W-1:0] wall_end_z;
    logic signed [FLD_W-1:0] span_bottom_at_start;
    logic signed [FLD_W-1:0] span_bottom_at_end;
    logic signed [FLD_W-1:0] span_top_at_start;
    logic signed [FLD_W-1:0] span_top_at_end;
  } sws_in_t;

  typedef struct packed {
    logic                    hit;
    logic                    stepped;
    logic signed [FLD_W-1:0] centre_x;
    logic signed [FLD_W-1:0] centre_y;
    logic signed [FLD_W-1:0] centre_z;
    logic signed [FLD_W-1:0] velocity_x;
    logic signed [FLD_W-1:0] velocity_y;
    logic signed [FLD_W-1:0] velocity_z;
  } sws_out_t;

  // clamp to +-(2^31-1)
  function automatic logic signed [31:0] sat31(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > S31_MAX) r = 32'(S31_MAX);
    else if (x < -S31_MAX) r = 32'(-S31_MAX);
    else r = 32'(x);
    return r;
  endfunction

  // clamp to the signed range of a state word
  function automatic logic signed [WORD_W-1:0] satw(input logic signed [63:0] x);
    logic signed [WORD_W-1:0] r;
    if (x > W_MAX) r = WORD_W'(W_MAX);
    else if (x < W_MIN) r = WORD_W'(W_MIN);
    else r = WORD_W'(x);
    return r;
  endfunction

endpackage

/* sv/sphere_wall_span_collision.sv */
// Sphere against wall-span collision response, Q16.16, top level.
// Depends on sws_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Keeps one sphere centre and velocity. A load beat writes one component and
// returns nothing. A test beat runs a sequencer around one shared 34x32
// multiplier, a restoring divider (one quotient bit per cycle) and a
// digit-by-digit square root. A box reject goes straight to its result; a
// full push-out divides for t, takes the distance root, divides for the normal
// ratio test, takes the normal length root and divides twice for the unit
// normal, between multiply and sequencing steps. The input is stalled from
// the accepted test beat until its result beat is taken.
// Configuration writes are always ready.
module sphere_wall_span_collision (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sws_pkg::sws_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sws_pkg::sws_out_t               out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sws_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sws_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import sws_pkg::*;

  state_e state_q, state_d;

  // configuration
  logic [RAD_W-1:0]  rad_q;
  logic [STEP_W-1:0] shl_q;
  logic [EPS_W-1:0]  eps_q;

  // body state
  logic signed [WORD_W-1:0] cx_q, cy_q, cz_q, vlx_q, vly_q, vlz_q;
  logic hit_q, stp_q;

  // work registers
  sws_in_t in_q;
  logic signed [31:0] vx_q, vz_q, tx_q, tz_q, dx_q, dy_q, dz_q, ax_q, az_q;
  logic [63:0] lensq_q, h_q, safe_q, dsq_q;
  logic signed [PROD_W-1:0] acc_q, prod_q;
  logic [16:0] t_q;
  logic signed [33:0] bot_q, top_q, clx_q, cly_q, clz_q;
  logic [33:0] dist_q;
  logic signed [34:0] pen_q;
  logic signed [17:0] ux_q, uz_q;
  logic signed [33:0] vin_q;
  logic [30:0] corr_q;
  logic [31:0] len_q;

  // divider
  logic        dv_start, dv_int;
  logic [63:0] dv_num, dv_den;
  logic        dv_busy_q;
  logic [63:0] dv_r_q, dv_d_q;
  logic [33:0] dv_n_q, dv_q;
  logic [DIV_CNT_W-1:0] dv_cnt_q;
  logic [64:0] dv_r2;
  logic [63:0] dv_dsh, dv_nsh;

  // square root
  logic        sq_start;
  logic [63:0] sq_arg;
  logic        sq_busy_q;
  logic [63:0] sq_v_q, sq_res_q, sq_bit_q, sq_sum;

  // multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [49:0]        pfl;

  logic in_acc, out_acc;
  logic signed [31:0] sx, sz, ex, ez, bs, be, ts, te;
  logic signed [RAD_W:0]  rad_s;
  logic signed [EPS_W:0]  eps_s;
  logic [32:0]            epsq;
  logic signed [33:0]     epsq_s;
  logic signed [33:0]     dbe, dte;
  logic signed [33:0]     xlo, xhi, ylo, yhi, zlo, zhi;
  logic                   box_miss;
  logic signed [PROD_W-1:0] sum2;
  logic signed [34:0]     pen_c;
  logic signed [63:0]     feet, steph;
  logic                   step_ok;
  logic [31:0]            axa, aza;
  logic signed [33:0]     tsc;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_OUT);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign sx = in_q.wall_start_x;
  assign sz = in_q.wall_start_z;
  assign ex = in_q.wall_end_x;
  assign ez = in_q.wall_end_z;
  assign bs = in_q.span_bottom_at_start;
  assign be = in_q.span_bottom_at_end;
  assign ts = in_q.span_top_at_start;
  assign te = in_q.span_top_at_end;

  assign rad_s  = $signed({1'b0, rad_q});
  assign eps_s  = $signed({1'b0, eps_q});
  assign epsq   = {eps_q, 16'd0};
  assign epsq_s = $signed({1'b0, epsq});
  assign dbe    = 34'(be) - 34'(bs);
  assign dte    = 34'(te) - 34'(ts);
  assign pfl    = $signed(prod_q[PROD_W-1:16]);
  assign sum2   = acc_q + prod_q;
  assign tsc    = 34'(ts + pfl);

  // box around the wall grown by the radius
  always_comb begin
    xlo = ((sx < ex) ? 34'(sx) : 34'(ex)) - 34'(rad_s);
    xhi = ((sx > ex) ? 34'(sx) : 34'(ex)) + 34'(rad_s);
    zlo = ((sz < ez) ? 34'(sz) : 34'(ez)) - 34'(rad_s);
    zhi = ((sz > ez) ? 34'(sz) : 34'(ez)) + 34'(rad_s);
    ylo = ((bs < be) ? 34'(bs) : 34'(be)) - 34'(rad_s);
    yhi = ((ts > te) ? 34'(ts) : 34'(te)) + 34'(rad_s);
    box_miss = (cx_q < xlo) || (cx_q > xhi) || (cy_q < ylo) || (cy_q > yhi) ||
               (cz_q < zlo) || (cz_q > zhi);
  end

  assign pen_c = 35'(rad_s) - $signed({1'b0, dist_q});
  assign axa   = ax_q[31] ? 32'(-ax_q) : 32'(ax_q);
  assign aza   = az_q[31] ? 32'(-az_q) : 32'(az_q);

  always_comb begin
    feet  = 64'(cy_q) - 64'(rad_s);
    steph = 64'(top_q) - feet;
    step_ok = (shl_q != '0) &&
              (64'(bot_q) <= feet + 64'(GROUND_SLOP)) &&
              (steph > 64'(eps_s)) &&
              (steph <= 64'($signed({1'b0, shl_q})) + 64'(eps_s)) &&
              (64'(vin_q) < -64'(eps_s));
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_L1: begin mul_a = 34'(vx_q);  mul_b = vx_q; end
      S_L2: begin mul_a = 34'(vz_q);  mul_b = vz_q; end
      S_L3: begin mul_a = 34'(tx_q);  mul_b = vx_q; end
      S_L4: begin mul_a = 34'(tz_q);  mul_b = vz_q; end
      S_I1: begin mul_a = dbe;        mul_b = 32'(t_q); end
      S_I2: begin mul_a = dte;        mul_b = 32'(t_q); end
      S_I3: begin mul_a = 34'(vx_q);  mul_b = 32'(t_q); end
      S_I4: begin mul_a = 34'(vz_q);  mul_b = 32'(t_q); end
      S_D1: begin mul_a = 34'(dx_q);  mul_b = dx_q; end
      S_D2: begin mul_a = 34'(dy_q);  mul_b = dy_q; end
      S_D3: begin mul_a = 34'(dz_q);  mul_b = dz_q; end
      S_D4: begin mul_a = 34'(rad_s); mul_b = 32'(rad_s); end
      S_F1: begin mul_a = 34'(tx_q);  mul_b = vz_q; end
      S_F2: begin mul_a = 34'(tz_q);  mul_b = vx_q; end
      S_A1: begin mul_a = 34'(ax_q);  mul_b = ax_q; end
      S_A2: begin mul_a = 34'(az_q);  mul_b = az_q; end
      S_V1: begin mul_a = 34'(ux_q);  mul_b = sat31(64'(vlx_q)); end
      S_V2: begin mul_a = 34'(uz_q);  mul_b = sat31(64'(vlz_q)); end
      S_P1: begin mul_a = 34'(corr_q); mul_b = 32'(ux_q); end
      S_P2: begin mul_a = 34'(corr_q); mul_b = 32'(uz_q); end
      S_P3: begin mul_a = vin_q;      mul_b = 32'(ux_q); end
      S_P4: begin mul_a = vin_q;      mul_b = 32'(uz_q); end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    dv_start = 1'b0;
    dv_int   = 1'b0;
    dv_num   = '0;
    dv_den   = '0;
    sq_start = 1'b0;
    sq_arg   = '0;
    unique case (state_q)
      S_IDLE: if (in_acc && action_e'(in_data_i.action) == ACT_TEST) state_d = S_BOX;
      S_BOX:  state_d = box_miss ? S_OUT : S_L1;
      S_L1:   state_d = S_L2;
      S_L2:   state_d = S_L3;
      S_L3:   state_d = S_L4;
      S_L4:   state_d = (lensq_q <= 64'(epsq)) ? S_OUT : S_L5;
      S_L5: begin
        if (sum2 <= 0) begin
          state_d = S_I1;
        end else begin
          dv_start = 1'b1;
          dv_num   = sum2[63:0];
          dv_den   = lensq_q;
          state_d  = S_TDIV;
        end
      end
      S_TDIV: if (!dv_busy_q) state_d = S_I1;
      S_I1:   state_d = S_I2;
      S_I2:   state_d = S_I3;
      S_I3:   state_d = S_I4;
      S_I4:   state_d = S_I5;
      S_I5:   state_d = S_D0;
      S_D0:   state_d = S_D1;
      S_D1:   state_d = S_D2;
      S_D2:   state_d = S_D3;
      S_D3:   state_d = S_D4;
      S_D4:   state_d = S_D5;
      S_D5: begin
        sq_arg = (acc_q > 66'(epsq_s)) ? acc_q[63:0] : 64'(epsq);
        if (acc_q >= prod_q) begin
          state_d = S_OUT;
        end else begin
          sq_start = 1'b1;
          state_d  = (acc_q > 66'(epsq_s)) ? S_DSQ : S_ESQ;
        end
      end
      S_DSQ: if (!sq_busy_q) state_d = S_PEN;
      S_ESQ: begin
        if (!sq_busy_q) begin
          if (sq_res_q == '0) begin
            state_d = S_PEN;
          end else begin
            dv_start = 1'b1;
            dv_int   = 1'b1;
            dv_num   = 64'(dsq_q[33:0]);
            dv_den   = sq_res_q;
            state_d  = S_EDIV;
          end
        end
      end
      S_EDIV: if (!dv_busy_q) state_d = S_PEN;
      S_PEN: begin
        if (pen_c <= 35'(eps_s)) begin
          state_d = S_OUT;
        end else begin
          dv_start = 1'b1;
          dv_num   = h_q;
          dv_den   = safe_q;
          state_d  = S_HDIV;
        end
      end
      S_HDIV: begin
        if (!dv_busy_q) begin
          if (dv_q > 34'(eps_q)) state_d = S_A1;
          else if (eps_q >= EPS_W'(ONE_Q16)) state_d = S_OUT;
          else state_d = S_F1;
        end
      end
      S_F1: state_d = S_F2;
      S_F2: state_d = S_F3;
      S_F3: state_d = S_A1;
      S_A1: state_d = S_A2;
      S_A2: state_d = S_A3;
      S_A3: begin
        sq_start = 1'b1;
        sq_arg   = sum2[63:0];
        state_d  = S_LSQ;
      end
      S_LSQ: begin
        if (!sq_busy_q) begin
          if (sq_res_q == '0) begin
            state_d = S_OUT;
          end else begin
            dv_start = 1'b1;
            dv_num   = 64'(axa);
            dv_den   = sq_res_q;
            state_d  = S_UXD;
          end
        end
      end
      S_UXD: begin
        if (!dv_busy_q) begin
          dv_start = 1'b1;
          dv_num   = 64'(aza);
          dv_den   = 64'(len_q);
          state_d  = S_UZD;
        end
      end
      S_UZD: if (!dv_busy_q) state_d = S_V1;
      S_V1:  state_d = S_V2;
      S_V2:  state_d = S_V3;
      S_V3:  state_d = S_DEC;
      S_DEC: state_d = step_ok ? S_OUT : S_P1;
      S_P1:  state_d = S_P2;
      S_P2:  state_d = S_P3;
      S_P3:  state_d = S_P4;
      S_P4:  state_d = S_P5;
      S_P5:  state_d = S_OUT;
      S_OUT: if (out_acc) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= RAD_RESET;
      shl_q <= STEP_RESET;
      eps_q <= EPS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_i)
        CFG_RADIUS: rad_q <= cfg_data_i[RAD_W-1:0];
        CFG_STEP:   shl_q <= cfg_data_i[STEP_W-1:0];
        CFG_EPS:    eps_q <= cfg_data_i[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // body state and result flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q  <= '0;
      cy_q  <= '0;
      cz_q  <= '0;
      vlx_q <= '0;
      vly_q <= '0;
      vlz_q <= '0;
      hit_q <= 1'b0;
      stp_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc && action_e'(in_data_i.action) == ACT_LOAD) begin
            unique case (in_data_i.body_axis)
              AX_CX:   cx_q  <= WORD_W'(in_data_i.body_value);
              AX_CY:   cy_q  <= WORD_W'(in_data_i.body_value);
              AX_CZ:   cz_q  <= WORD_W'(in_data_i.body_value);
              AX_VX:   vlx_q <= WORD_W'(in_data_i.body_value);
              AX_VY:   vly_q <= WORD_W'(in_data_i.body_value);
              AX_VZ:   vlz_q <= WORD_W'(in_data_i.body_value);
              default: ;
            endcase
          end else if (in_acc) begin
            hit_q <= 1'b0;
            stp_q <= 1'b0;
          end
        end
        S_DEC: begin
          if (step_ok) begin
            cy_q  <= satw(64'(cy_q) + steph + 64'(PEN_SLOP));
            if (vly_q < 0) vly_q <= '0;
            hit_q <= 1'b1;
            stp_q <= 1'b1;
          end
        end
        S_P2: cx_q <= satw(64'(cx_q) + 64'(pfl));
        S_P3: cz_q <= satw(64'(cz_q) + 64'(pfl));
        S_P4: if (vin_q < 0) vlx_q <= satw(64'(vlx_q) - 64'(pfl));
        S_P5: begin
          if (vin_q < 0) vlz_q <= satw(64'(vlz_q) - 64'(pfl));
          hit_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (in_acc) in_q <= in_data_i;
      S_BOX: begin
        vx_q <= sat31(64'(ex) - 64'(sx));
        vz_q <= sat31(64'(ez) - 64'(sz));
        tx_q <= sat31(64'(cx_q) - 64'(sx));
        tz_q <= sat31(64'(cz_q) - 64'(sz));
      end
      S_L2: acc_q <= prod_q;
      S_L3: lensq_q <= sum2[63:0];
      S_L4: acc_q <= prod_q;
      S_L5: if (sum2 <= 0) t_q <= '0;
      S_TDIV: if (!dv_busy_q) t_q <= dv_q[16:0];
      S_I2: bot_q <= 34'(bs + pfl);
      S_I3: top_q <= (tsc > bot_q) ? tsc : bot_q;
      S_I4: clx_q <= 34'(sx + pfl);
      S_I5: begin
        clz_q <= 34'(sz + pfl);
        if (cy_q < bot_q) cly_q <= bot_q;
        else if (cy_q > top_q) cly_q <= top_q;
        else cly_q <= 34'(cy_q);
      end
      S_D0: begin
        dx_q <= sat31(64'(cx_q) - 64'(clx_q));
        dy_q <= sat31(64'(cy_q) - 64'(cly_q));
        dz_q <= sat31(64'(cz_q) - 64'(clz_q));
      end
      S_D2: begin
        acc_q <= prod_q;
        h_q   <= prod_q[63:0];
      end
      S_D3: acc_q <= sum2;
      S_D4: begin
        acc_q <= sum2;
        h_q   <= h_q + prod_q[63:0];
      end
      S_D5: begin
        dsq_q  <= acc_q[63:0];
        safe_q <= (acc_q > 66'(epsq_s)) ? acc_q[63:0] : 64'(epsq);
      end
      S_DSQ: if (!sq_busy_q) dist_q <= sq_res_q[33:0];
      S_ESQ: if (!sq_busy_q && sq_res_q == '0) dist_q <= '0;
      S_EDIV: if (!dv_busy_q) dist_q <= dv_q;
      S_PEN: pen_q <= pen_c;
      S_HDIV: begin
        if (!dv_busy_q && dv_q > 34'(eps_q)) begin
          ax_q <= dx_q;
          az_q <= dz_q;
        end
      end
      S_F2: acc_q <= prod_q;
      S_F3: begin
        // wall perpendicular turned to the centre's side
        if ((acc_q - prod_q) < 0) begin
          ax_q <= -vz_q;
          az_q <= vx_q;
        end else begin
          ax_q <= vz_q;
          az_q <= -vx_q;
        end
      end
      S_A2: acc_q <= prod_q;
      S_LSQ: if (!sq_busy_q) len_q <= sq_res_q[31:0];
      S_UXD: begin
        if (!dv_busy_q) begin
          ux_q <= ax_q[31] ? -$signed({1'b0, dv_q[16:0]}) : $signed({1'b0, dv_q[16:0]});
        end
      end
      S_UZD: begin
        if (!dv_busy_q) begin
          uz_q <= az_q[31] ? -$signed({1'b0, dv_q[16:0]}) : $signed({1'b0, dv_q[16:0]});
        end
      end
      S_V2: acc_q <= prod_q;
      S_V3: vin_q <= 34'(sum2 >>> 16);
      S_DEC: corr_q <= (pen_q > 35'sd66) ? 31'(pen_q - 35'sd66) : '0;
      default: ;
    endcase
  end

  // restoring divider: fraction mode gives floor(num*2^16/den) for num < den,
  // integer mode gives floor(num/den) for a 34-bit num
  assign dv_dsh = dv_den[63] ? (dv_den >> 2) : (dv_den[62] ? (dv_den >> 1) : dv_den);
  assign dv_nsh = dv_den[63] ? (dv_num >> 2) : (dv_den[62] ? (dv_num >> 1) : dv_num);
  assign dv_r2  = {dv_r_q, dv_n_q[33]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_busy_q <= 1'b0;
      dv_cnt_q  <= '0;
    end else if (dv_start) begin
      if (!dv_int && (dv_den == '0 || dv_num >= dv_den)) begin
        dv_busy_q <= 1'b0;
        dv_cnt_q  <= '0;
      end else begin
        dv_busy_q <= 1'b1;
        dv_cnt_q  <= dv_int ? DIV_CNT_W'(DIV_INT_STEPS) : DIV_CNT_W'(DIV_FRAC_STEPS);
      end
    end else if (dv_busy_q) begin
      dv_cnt_q <= dv_cnt_q - 1'b1;
      if (dv_cnt_q == DIV_CNT_W'(1)) dv_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_start) begin
      if (dv_int) begin
        dv_r_q <= '0;
        dv_d_q <= dv_den;
        dv_n_q <= dv_num[33:0];
        dv_q   <= '0;
      end else begin
        dv_r_q <= dv_nsh;
        dv_d_q <= dv_dsh;
        dv_n_q <= '0;
        if (dv_den == '0) dv_q <= '0;
        else if (dv_num >= dv_den) dv_q <= 34'(ONE_Q16);
        else dv_q <= '0;
      end
    end else if (dv_busy_q) begin
      dv_n_q <= dv_n_q << 1;
      if (dv_r2 >= {1'b0, dv_d_q}) begin
        dv_r_q <= 64'(dv_r2 - {1'b0, dv_d_q});
        dv_q   <= {dv_q[32:0], 1'b1};
      end else begin
        dv_r_q <= dv_r2[63:0];
        dv_q   <= {dv_q[32:0], 1'b0};
      end
    end
  end

  // floor square root, two radicand bits per cycle
  assign sq_sum = sq_res_q + sq_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
    end else if (sq_start) begin
      sq_busy_q <= 1'b1;
    end else if (sq_busy_q && sq_bit_q == 64'd1) begin
      sq_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_start) begin
      sq_v_q   <= sq_arg;
      sq_res_q <= '0;
      sq_bit_q <= 64'd1 << 62;
    end else if (sq_busy_q) begin
      if (sq_v_q >= sq_sum) begin
        sq_v_q   <= sq_v_q - sq_sum;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  always_comb begin
    out_data_o.hit        = hit_q;
    out_data_o.stepped    = stp_q;
    out_data_o.centre_x   = cx_q[FLD_W-1:0];
    out_data_o.centre_y   = cy_q[FLD_W-1:0];
    out_data_o.centre_z   = cz_q[FLD_W-1:0];
    out_data_o.velocity_x = vlx_q[FLD_W-1:0];
    out_data_o.velocity_y = vly_q[FLD_W-1:0];
    out_data_o.velocity_z = vlz_q[FLD_W-1:0];
  end

  `ASSERT_CLK(a_out_blocks_in, out_valid_o |-> in_stall_o, "input taken while result pending")
  `ASSERT_CLK(a_step_is_hit, out_valid_o |-> (!out_data_o.stepped || out_data_o.hit), "step without hit")
  `ASSERT_NEVER(a_units_exclusive, dv_busy_q && sq_busy_q, "divider and root both busy")
  `ASSERT_CLK(a_load_no_result, (in_acc && !in_data_i.action) |=> !out_valid_o, "load made a result")

endmodule
